>>> sv/lmc_pkg.sv
// Shared types and constants for the letter multiset counter.
// Request/response structs, request and status codes, letter range.
// No dependencies.
package lmc_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam logic [7:0] LETTER_FIRST = 8'd97;   // 'a'
	localparam logic [7:0] LETTER_LAST  = 8'd122;  // 'z'
	localparam int         NUM_LETTERS  = 26;
	localparam int         IDX_W        = 5;

	localparam logic [1:0] REQ_INSERT  = 2'd0;
	localparam logic [1:0] REQ_EXTRACT = 2'd1;
	localparam logic [1:0] REQ_SET_CAP = 2'd2;

	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_BAD_LETTER = 2'd1;
	localparam logic [1:0] STS_FULL       = 2'd2;
	localparam logic [1:0] STS_CAP_SMALL  = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  letter;
		logic [15:0] new_capacity;
	} lmc_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] total_count;
		logic [15:0] capacity_now;
		logic [15:0] letter_count;
	} lmc_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;     // apply the request to the counters
		logic capture;  // load the response register
	} lmc_cmd_t;

endpackage

>>> sv/lmc_ctrl.sv
// Handshake controller for the letter multiset counter.
// Tracks occupancy of the response register; issues commands to lmc_datapath.
// Depends on lmc_pkg.
module lmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lmc_pkg::lmc_cmd_t cmd
);
	import lmc_pkg::*;

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_HOLD  = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   take;

	// a new request may enter while the held response leaves in the same cycle
	assign req_ready   = (state_q == ST_EMPTY) || rsp_ready;
	assign take        = req_valid && req_ready;
	assign rsp_valid   = (state_q == ST_HOLD);
	assign cmd.exec    = take;
	assign cmd.capture = take;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (take)
					state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (rsp_ready && !take)
					state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_EMPTY;
		else
			state_q <= state_d;
	end

endmodule

>>> sv/lmc_datapath.sv
// Datapath: per-letter counters, total, capacity and the response register.
// Driven by lmc_ctrl commands. Depends on lmc_pkg.
module lmc_datapath #(
	parameter int COUNT_BITS = lmc_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lmc_pkg::lmc_cmd_t cmd,
	input  lmc_pkg::lmc_req_t req,
	output lmc_pkg::lmc_rsp_t rsp
);
	import lmc_pkg::*;

	localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	logic [COUNT_BITS-1:0] counts_q [NUM_LETTERS];
	logic [COUNT_BITS-1:0] total_q, capacity_q;
	lmc_rsp_t              rsp_q;

	logic                  is_letter;
	logic [7:0]            offs;
	logic [IDX_W-1:0]      idx;
	logic [COUNT_BITS-1:0] cur_cnt, new_cnt, new_total, new_cap, cap_req;
	logic [CMP_W-1:0]      want_ext;
	logic [1:0]            status;
	logic                  cnt_we, cap_we;

	assign is_letter = (req.letter >= LETTER_FIRST) && (req.letter <= LETTER_LAST);
	assign offs      = req.letter - LETTER_FIRST;
	assign idx       = is_letter ? offs[IDX_W-1:0] : '0;
	assign cur_cnt   = counts_q[idx];

	// requested capacity saturates to the counter range
	assign want_ext = CMP_W'(req.new_capacity);
	assign cap_req  = (want_ext > CMP_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(want_ext);

	always_comb begin
		status    = STS_OK;
		new_cnt   = cur_cnt;
		new_total = total_q;
		new_cap   = capacity_q;
		cnt_we    = 1'b0;
		cap_we    = 1'b0;
		case (req.req_type)
			REQ_INSERT: begin
				if (!is_letter)
					status = STS_BAD_LETTER;
				else if (total_q >= capacity_q)
					status = STS_FULL;
				else begin
					new_cnt   = cur_cnt + COUNT_ONE;
					new_total = total_q + COUNT_ONE;
					cnt_we    = 1'b1;
				end
			end
			REQ_EXTRACT: begin
				if (!is_letter)
					status = STS_BAD_LETTER;
				else begin
					new_cnt   = '0;
					new_total = (cur_cnt > total_q) ? '0 : total_q - cur_cnt;
					cnt_we    = 1'b1;
				end
			end
			REQ_SET_CAP: begin
				if (cap_req < total_q)
					status = STS_CAP_SMALL;
				else begin
					new_cap = cap_req;
					cap_we  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LETTERS; i++)
				counts_q[i] <= '0;
			total_q    <= '0;
			capacity_q <= '0;
		end else if (cmd.exec) begin
			if (cnt_we) begin
				counts_q[idx] <= new_cnt;
				total_q       <= new_total;
			end
			if (cap_we)
				capacity_q <= new_cap;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rsp_q.status       <= status;
			rsp_q.total_count  <= 16'(new_total);
			rsp_q.capacity_now <= 16'(new_cap);
			rsp_q.letter_count <= is_letter ? 16'(new_cnt) : 16'd0;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> sv/letter_multiset_counter.sv
// Letter multiset counter: 26 letter counters, a total and a capacity.
// The response is valid in the cycle after its request transfers.
// Throughput: 1 request per cycle; the response register is refilled in the
// same cycle its content transfers out, so only a stalled response holds input.
// Reset (arst_n low, async): all counters, total and capacity cleared to zero,
// response register empty.
module letter_multiset_counter #(
	parameter int COUNT_BITS = lmc_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  lmc_pkg::lmc_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lmc_pkg::lmc_rsp_t rsp
);
	import lmc_pkg::*;

	lmc_cmd_t cmd;

	// Controller: decides when a request transfers and when the response
	// register is loaded or drained.
	lmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Datapath: one counter read and at most one counter write per request, total
	// and capacity update, and the registered response.
	lmc_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
